@@ src/tci_pkg.sv @@
// ----------------------------------------------------------------------------
// Thrust curve interpolator package
// Shared types, constants and controller codes.
// ----------------------------------------------------------------------------
package tci_pkg;

    localparam int MAX_ROWS = 64;
    localparam int IDX_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic [1:0] REGION_START = 2'd0;
    localparam logic [1:0] REGION_INTERP = 2'd1;
    localparam logic [1:0] REGION_END   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] sample_time;
        logic [31:0] thrust_in;
        logic [31:0] mass_in;
    } t_in_item;

    typedef struct packed {
        logic [31:0] thrust_out;
        logic [31:0] mass_out;
        logic [1:0]  region;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_CHK0,
        ST_RDSEG,
        ST_CHKSEG,
        ST_DIVT,
        ST_DIVM,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;       // capture input item
        logic do_append;
        logic do_clear;
        logic rd_first;   // read row 0 and last row
        logic rd_seg;     // read rows idx-1, idx
        logic seg_next;   // advance segment index
        logic set_start;
        logic set_end;
        logic set_empty;
        logic set_full;
        logic div_start_t;
        logic div_start_m;
        logic set_interp;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
        logic le_first;
        logic ge_last;
        logic bracket;
        logic seg_last;
        logic div_busy;
    } t_sts;

endpackage

@@ src/tci_divider.sv @@
// ----------------------------------------------------------------------------
// Thrust curve interpolator divider
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module tci_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    import tci_pkg::*;

    logic [63:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic [32:0] w_try;

    assign w_try = {r_rem[31:0], r_num[63]} - {1'b0, r_den};

    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_start) begin
            n_num = i_num;
            n_rem = '0;
            n_cnt = 7'd64;
        end else if (r_cnt != 7'd0) begin
            n_num = {r_num[62:0], 1'b0};
            n_cnt = r_cnt - 7'd1;
            if (!w_try[32]) begin
                n_rem    = w_try;
                n_num[0] = 1'b1;
            end else begin
                n_rem = {r_rem[31:0], r_num[63]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = (r_cnt != 7'd0);
    assign o_quot = r_num[31:0];
endmodule

@@ src/tci_datapath.sv @@
// ----------------------------------------------------------------------------
// Thrust curve interpolator datapath
// Row memories, segment search registers, interpolation and result register.
// ----------------------------------------------------------------------------
module tci_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tci_pkg::t_in_item   i_item,
    input  tci_pkg::t_ctl       i_ctl,
    output tci_pkg::t_sts       o_sts,
    output tci_pkg::t_out_item  o_result
);
    import tci_pkg::*;

    logic [31:0] mem_time   [MAX_ROWS];
    logic [31:0] mem_thrust [MAX_ROWS];
    logic [31:0] mem_mass   [MAX_ROWS];

    t_in_item    r_item;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] w_ra, w_rb;
    logic [31:0] r_ta, r_tb, r_tha, r_thb, r_ma, r_mb;
    t_out_item   r_res;
    logic [31:0] w_span, w_dt, w_th_mag, w_m_mag, w_mag, w_quot;
    logic        w_th_up, w_m_up, r_div_m;
    logic [63:0] w_num;
    logic        w_busy;
    logic [CNT_W-1:0] w_last;
    logic [31:0] w_v0;
    logic        w_up;

    assign w_last = r_count - CNT_W'(1);

    always_comb begin
        w_ra = '0;
        w_rb = w_last[IDX_W-1:0];
        if (i_ctl.rd_seg) begin
            w_ra = IDX_W'(r_idx - CNT_W'(1));
            w_rb = r_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.do_append) begin
            mem_time[r_count[IDX_W-1:0]]   <= r_item.sample_time;
            mem_thrust[r_count[IDX_W-1:0]] <= r_item.thrust_in;
            mem_mass[r_count[IDX_W-1:0]]   <= r_item.mass_in;
        end
        if (i_ctl.rd_first || i_ctl.rd_seg) begin
            r_ta  <= mem_time[w_ra];
            r_tha <= mem_thrust[w_ra];
            r_ma  <= mem_mass[w_ra];
            r_tb  <= mem_time[w_rb];
            r_thb <= mem_thrust[w_rb];
            r_mb  <= mem_mass[w_rb];
        end
    end

    assign w_span   = r_tb - r_ta;
    assign w_dt     = r_item.sample_time - r_ta;
    assign w_th_up  = (r_thb >= r_tha);
    assign w_m_up   = (r_mb >= r_ma);
    assign w_th_mag = w_th_up ? (r_thb - r_tha) : (r_tha - r_thb);
    assign w_m_mag  = w_m_up ? (r_mb - r_ma) : (r_ma - r_mb);
    assign w_mag    = i_ctl.div_start_m ? w_m_mag : w_th_mag;
    assign w_num    = 64'(w_dt) * 64'(w_mag);

    tci_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start_t || i_ctl.div_start_m),
        .i_num   (w_num),
        .i_den   (w_span),
        .o_busy  (w_busy),
        .o_quot  (w_quot)
    );

    assign w_v0 = r_div_m ? r_ma : r_tha;
    assign w_up = r_div_m ? w_m_up : w_th_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.do_clear) begin
            r_count <= '0;
        end else if (i_ctl.do_append) begin
            r_count <= r_count + CNT_W'(1);
        end
        if (i_ctl.load) begin
            r_item <= i_item;
            r_res  <= '0;
            r_idx  <= CNT_W'(1);
        end
        if (i_ctl.seg_next) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_ctl.div_start_t) begin
            r_div_m <= 1'b0;
        end
        if (i_ctl.div_start_m) begin
            r_div_m <= 1'b1;
        end
        if (i_ctl.set_full) begin
            r_res.status <= STATUS_FULL;
        end
        if (i_ctl.set_empty) begin
            r_res.status <= STATUS_EMPTY;
        end
        if (i_ctl.set_start) begin
            r_res.thrust_out <= r_tha;
            r_res.mass_out   <= r_ma;
            r_res.region     <= REGION_START;
        end
        if (i_ctl.set_end) begin
            r_res.thrust_out <= '0;
            r_res.mass_out   <= r_mb;
            r_res.region     <= REGION_END;
        end
        if (i_ctl.set_interp) begin
            r_res.region <= REGION_INTERP;
            if (w_span == '0) begin
                if (r_div_m) r_res.mass_out <= r_ma;
                else         r_res.thrust_out <= r_tha;
            end else if (r_div_m) begin
                r_res.mass_out <= w_up ? w_v0 + w_quot : w_v0 - w_quot;
            end else begin
                r_res.thrust_out <= w_up ? w_v0 + w_quot : w_v0 - w_quot;
            end
        end
    end

    assign o_sts.cmd      = t_cmd'(r_item.command);
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count >= CNT_W'(MAX_ROWS));
    assign o_sts.le_first = (r_item.sample_time <= r_ta);
    assign o_sts.ge_last  = (r_item.sample_time >= r_tb);
    assign o_sts.bracket  = (r_item.sample_time >= r_ta) && (r_item.sample_time <= r_tb);
    assign o_sts.seg_last = (r_idx >= w_last);
    assign o_sts.div_busy = w_busy;
    assign o_result       = r_res;
endmodule

@@ src/tci_controller.sv @@
// ----------------------------------------------------------------------------
// Thrust curve interpolator controller
// Sequences command decode, segment scan and the two divisions.
// ----------------------------------------------------------------------------
module tci_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  tci_pkg::t_sts  i_sts,
    output tci_pkg::t_ctl  o_ctl
);
    import tci_pkg::*;

    t_state r_state, n_state;
    logic   r_div_m, n_div_m;

    always_comb begin
        n_state = r_state;
        n_div_m = r_div_m;
        unique case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_RD0;
            ST_RD0: begin
                unique case (i_sts.cmd)
                    CMD_QUERY: n_state = i_sts.empty ? ST_OUT : ST_CHK0;
                    default:   n_state = ST_OUT;
                endcase
            end
            ST_CHK0: begin
                if (i_sts.le_first || i_sts.ge_last) n_state = ST_OUT;
                else n_state = ST_CHKSEG;
            end
            ST_RDSEG:  n_state = ST_CHKSEG;
            ST_CHKSEG: begin
                if (i_sts.bracket) begin
                    n_state = ST_DIVT;
                    n_div_m = 1'b0;
                end else if (i_sts.seg_last) n_state = ST_OUT;
                else n_state = ST_RDSEG;
            end
            ST_DIVT:   n_state = ST_FINISH;
            ST_DIVM:   n_state = ST_FINISH;
            ST_FINISH: begin
                if (!i_sts.div_busy) begin
                    n_state = r_div_m ? ST_OUT : ST_DIVM;
                    n_div_m = 1'b1;
                end
            end
            ST_OUT:    if (!i_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            ST_IDLE: o_ctl.load = i_valid;
            ST_RD0: begin
                o_ctl.rd_first = 1'b1;
                unique case (i_sts.cmd)
                    CMD_CLEAR:  o_ctl.do_clear = 1'b1;
                    CMD_APPEND: begin
                        o_ctl.do_append = !i_sts.full;
                        o_ctl.set_full  = i_sts.full;
                    end
                    CMD_QUERY:  o_ctl.set_empty = i_sts.empty;
                    default: ;
                endcase
            end
            ST_CHK0: begin
                o_ctl.set_start = i_sts.le_first;
                o_ctl.set_end   = !i_sts.le_first && i_sts.ge_last;
                o_ctl.rd_seg    = !i_sts.le_first && !i_sts.ge_last;
            end
            ST_RDSEG:  o_ctl.rd_seg = 1'b1;
            ST_CHKSEG: begin
                o_ctl.seg_next = !i_sts.bracket && !i_sts.seg_last;
                o_ctl.set_end  = !i_sts.bracket && i_sts.seg_last;
            end
            ST_DIVT:   o_ctl.div_start_t = 1'b1;
            ST_DIVM:   o_ctl.div_start_m = 1'b1;
            ST_FINISH: o_ctl.set_interp = !i_sts.div_busy;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_div_m <= 1'b0;
        end else begin
            r_state <= n_state;
            r_div_m <= n_div_m;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
endmodule

@@ src/thrust_curve_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// Thrust curve interpolator unit
// Table of thrust and mass rows with piecewise linear lookup by time.
//
//  channel | direction | payload
//  in      | input     | t_in_item: command, sample_time, thrust_in, mass_in
//  out     | output    | t_out_item: thrust_out, mass_out, region, status
//
// Clear, append and a query on an empty table go from decode straight to the
// output state. Other queries check the first and last rows, scan the N rows
// segment by segment, and when interpolating run two serial divisions. Reset
// empties the table at once; row contents stay undefined until written.
// A stalled result holds the unit.
// ----------------------------------------------------------------------------
module thrust_curve_interpolator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tci_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output tci_pkg::t_out_item  o_data
);
    import tci_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    tci_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    tci_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_data),
        .i_ctl    (w_ctl),
        .o_sts    (w_sts),
        .o_result (o_data)
    );

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accept while result pending");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("result lost");
    a_region_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != STATUS_OK |-> o_data.region == REGION_START)
        else $error("region on failed item");
endmodule
